// ===== rtl/igbc_pkg.sv =====
// Shared types and constants of the idle gap byte chunker.
package igbc_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_MS      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LIMIT = 1'd1;

	localparam logic [15:0] GAP_MS_RESET      = 16'd20;
	localparam logic [5:0]  CHUNK_LIMIT_RESET = 6'd48;

	// item function codes
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// per-chunk header carried from front to back
	typedef struct packed {
		logic [31:0] seq_no;
		logic        channel;
		logic [31:0] open_ms;
		logic [31:0] end_ms;
	} chunk_hdr_t;

	typedef struct packed {
		logic empty;
		logic room2;
	} fifo_stat_t;

endpackage

// ===== rtl/igbc_if.sv =====
// Handshake channels for input items and output chunk words.
interface igbc_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic        channel;
	logic [7:0]  rx_byte;
	logic [31:0] now_ms;

	modport source (output valid, func, channel, rx_byte, now_ms, input ready);
	modport sink (input valid, func, channel, rx_byte, now_ms, output ready);
endinterface

interface igbc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] seq_no;
	logic        chunk_channel;
	logic [31:0] open_ms;
	logic [31:0] end_ms;
	logic [5:0]  byte_index;
	logic [7:0]  chunk_byte;
	logic        last;

	modport source (output valid, seq_no, chunk_channel, open_ms, end_ms, byte_index,
		chunk_byte, last, input ready);
	modport sink (input valid, seq_no, chunk_channel, open_ms, end_ms, byte_index,
		chunk_byte, last, output ready);
endinterface

// ===== rtl/idle_gap_byte_chunker_top.sv =====
// Front end: a byte passes accept, bank wait, gap check, append; a time check skips append.
// Closed chunks leave word by word (single read port of the byte store, one read in flight);
// the first word passes the command queue, chunk registers, read stage and output register.
// An item stalls in bank wait while either bank of its channel is still being emitted or the
// close queue has room for fewer than two commands.
// arst_n (async) clears counts, banks, seq number, gap 20, limit 48; byte store not cleared.
module idle_gap_byte_chunker_top
	import igbc_pkg::*;
#(
	parameter int MAX_CHUNK    = 48,
	parameter int NUM_CHANNELS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	igbc_in_if.sink               item_in,
	igbc_out_if.source            chunk_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);
	localparam int CW        = $clog2(MAX_CHUNK + 1);
	localparam int AW        = $clog2(2 * NUM_CHANNELS * MAX_CHUNK);
	localparam int CHW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CMD_W     = $bits(chunk_hdr_t) + 1 + CW;
	localparam int CMD_DEPTH = 4;

	fifo_stat_t    q_stat;
	logic          cmd_push;
	chunk_hdr_t    cmd_hdr;
	logic          cmd_bank;
	logic [CW-1:0] cmd_count;
	logic          q_pop;
	logic [CMD_W-1:0] q_wdata;
	logic [CMD_W-1:0] q_rdata;
	chunk_hdr_t    q_hdr;
	logic          q_bank;
	logic [CW-1:0] q_count;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic          done_valid;
	logic [CHW:0]  done_slot;

	assign q_wdata = {cmd_hdr, cmd_bank, cmd_count};
	assign {q_hdr, q_bank, q_count} = q_rdata;

	igbc_front #(
		.MAX_CHUNK    (MAX_CHUNK),
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.q_stat     (q_stat),
		.cmd_push   (cmd_push),
		.cmd_hdr    (cmd_hdr),
		.cmd_bank   (cmd_bank),
		.cmd_count  (cmd_count),
		.mem_we     (mem_we),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.done_valid (done_valid),
		.done_slot  (done_slot)
	);

	igbc_cmd_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	igbc_back #(
		.MAX_CHUNK    (MAX_CHUNK),
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.q_hdr      (q_hdr),
		.q_bank     (q_bank),
		.q_count    (q_count),
		.q_pop      (q_pop),
		.mem_we     (mem_we),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.done_valid (done_valid),
		.done_slot  (done_slot),
		.chunk_out  (chunk_out)
	);

endmodule

// ===== rtl/igbc_cmd_fifo.sv =====
// Small show-ahead queue of closed-chunk commands between front and back.
module igbc_cmd_fifo
	import igbc_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output fifo_stat_t       stat
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      cnt_q;

	assign rdata      = slot_q[rd_ptr_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.room2 = (cnt_q <= (PW+1)'(DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < (PW+1)'(DEPTH)) || pop)
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("command queue underflow");

endmodule

// ===== rtl/igbc_front.sv =====
// Front end: takes items, keeps per-channel chunk state, writes bytes, queues closes.
module igbc_front
	import igbc_pkg::*;
#(
	parameter int MAX_CHUNK    = 48,
	parameter int NUM_CHANNELS = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	igbc_in_if.sink                             item_in,
	input  logic                                cfg_we,
	input  logic [CFG_IDX_W-1:0]                cfg_index,
	input  logic [CFG_DATA_W-1:0]               cfg_wdata,
	input  fifo_stat_t                          q_stat,
	output logic                                cmd_push,
	output chunk_hdr_t                          cmd_hdr,
	output logic                                cmd_bank,
	output logic [$clog2(MAX_CHUNK+1)-1:0]      cmd_count,
	output logic                                mem_we,
	output logic [$clog2(2*NUM_CHANNELS*MAX_CHUNK)-1:0] mem_addr,
	output logic [7:0]                          mem_wdata,
	input  logic                                done_valid,
	input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1):0] done_slot
);
	localparam int CW   = $clog2(MAX_CHUNK + 1);
	localparam int AW   = $clog2(2 * NUM_CHANNELS * MAX_CHUNK);
	localparam int CHW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SW   = CHW + 1;
	localparam int LIMW = (CW > 6) ? CW : 6;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_WAIT   = 2'd1;
	localparam logic [1:0] ST_CHECK  = 2'd2;
	localparam logic [1:0] ST_APPEND = 2'd3;

	logic [1:0]  state_q;
	logic        func_q;
	logic        ch_q;
	logic [7:0]  byte_q;
	logic [31:0] now_q;

	logic [CW-1:0] count_q  [NUM_CHANNELS];
	logic          bank_q   [NUM_CHANNELS];
	logic [31:0]   first_q  [NUM_CHANNELS];
	logic [31:0]   latest_q [NUM_CHANNELS];
	logic [31:0]   seq_q;
	logic [2*NUM_CHANNELS-1:0] pend_q;
	logic [2*NUM_CHANNELS-1:0] pend_nxt;
	logic [15:0]   gap_q;
	logic [5:0]    limit_q;

	logic [CHW-1:0]  cidx;
	logic [SW-1:0]   slot_cur;
	logic            ch_ok;
	logic [31:0]     gap_diff;
	logic            gap_hit;
	logic [CW-1:0]   n_cur;
	logic [CW-1:0]   n_next;
	logic [LIMW-1:0] lim_ext;
	logic [CW-1:0]   eff_lim;
	logic            lim_hit;
	logic            go;

	always_comb begin
		cidx     = CHW'(ch_q);
		slot_cur = {cidx, bank_q[cidx]};
		ch_ok    = (32'(ch_q) < 32'(NUM_CHANNELS));
		n_cur    = count_q[cidx];
		n_next   = n_cur + 1'b1;
		gap_diff = now_q - latest_q[cidx];
		gap_hit  = (n_cur != '0) && (gap_diff >= 32'(gap_q));
		// limit of zero acts as one, anything above the buffer size as the buffer size
		lim_ext  = LIMW'(limit_q);
		if (lim_ext == '0)
			eff_lim = CW'(1);
		else if (lim_ext > LIMW'(MAX_CHUNK))
			eff_lim = CW'(MAX_CHUNK);
		else
			eff_lim = CW'(lim_ext);
		lim_hit = (n_next >= eff_lim);
		go      = ch_ok && !pend_q[{cidx, 1'b0}] && !pend_q[{cidx, 1'b1}] && q_stat.room2;
	end

	assign item_in.ready = (state_q == ST_IDLE);

	always_comb begin
		cmd_hdr.seq_no  = seq_q + 32'd1;
		cmd_hdr.channel = ch_q;
		cmd_bank        = bank_q[cidx];
		if (state_q == ST_CHECK) begin
			cmd_push        = gap_hit;
			cmd_hdr.open_ms = first_q[cidx];
			cmd_hdr.end_ms  = latest_q[cidx];
			cmd_count       = n_cur;
		end else begin
			cmd_push        = (state_q == ST_APPEND) && lim_hit;
			cmd_hdr.open_ms = (n_cur == '0) ? now_q : first_q[cidx];
			cmd_hdr.end_ms  = now_q;
			cmd_count       = n_next;
		end
		mem_we    = (state_q == ST_APPEND);
		mem_addr  = AW'(slot_cur) * AW'(MAX_CHUNK) + AW'(n_cur);
		mem_wdata = byte_q;
	end

	// bank release from the back end and bank claim by a close, merged
	always_comb begin
		pend_nxt = pend_q;
		if (done_valid)
			pend_nxt[done_slot] = 1'b0;
		if (cmd_push)
			pend_nxt[slot_cur] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seq_q   <= '0;
			pend_q  <= '0;
			gap_q   <= GAP_MS_RESET;
			limit_q <= CHUNK_LIMIT_RESET;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				count_q[c] <= '0;
				bank_q[c]  <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GAP_MS:      gap_q   <= cfg_wdata[15:0];
					REG_CHUNK_LIMIT: limit_q <= cfg_wdata[5:0];
					default: ;
				endcase
			end
			pend_q <= pend_nxt;
			if (cmd_push) begin
				bank_q[cidx] <= !bank_q[cidx];
				seq_q        <= seq_q + 32'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_in.valid)
						state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!ch_ok)
						state_q <= ST_IDLE;
					else if (go)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (gap_hit)
						count_q[cidx] <= '0;
					state_q <= (func_q == FUNC_BYTE) ? ST_APPEND : ST_IDLE;
				end
				ST_APPEND: begin
					count_q[cidx] <= lim_hit ? '0 : n_next;
					state_q       <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			func_q <= item_in.func;
			ch_q   <= item_in.channel;
			byte_q <= item_in.rx_byte;
			now_q  <= item_in.now_ms;
		end
		if (state_q == ST_APPEND) begin
			if (n_cur == '0)
				first_q[cidx] <= now_q;
			latest_q[cidx] <= now_q;
		end
	end

	// bytes only go into a bank the back end has finished reading
	a_write_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !pend_q[slot_cur])
		else $error("byte written into a bank still being emitted");

	a_done_was_pending: assert property (@(posedge clk) disable iff (!arst_n)
		done_valid |-> pend_q[done_slot])
		else $error("release of a bank that was not pending");

endmodule

// ===== rtl/igbc_back.sv =====
// Back end: byte store, reads closed chunks out word by word into the output register.
module igbc_back
	import igbc_pkg::*;
#(
	parameter int MAX_CHUNK    = 48,
	parameter int NUM_CHANNELS = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fifo_stat_t                          q_stat,
	input  chunk_hdr_t                          q_hdr,
	input  logic                                q_bank,
	input  logic [$clog2(MAX_CHUNK+1)-1:0]      q_count,
	output logic                                q_pop,
	input  logic                                mem_we,
	input  logic [$clog2(2*NUM_CHANNELS*MAX_CHUNK)-1:0] mem_addr,
	input  logic [7:0]                          mem_wdata,
	output logic                                done_valid,
	output logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1):0] done_slot,
	igbc_out_if.source                          chunk_out
);
	localparam int CW    = $clog2(MAX_CHUNK + 1);
	localparam int AW    = $clog2(2 * NUM_CHANNELS * MAX_CHUNK);
	localparam int CHW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SW    = CHW + 1;
	localparam int DEPTH = 2 * NUM_CHANNELS * MAX_CHUNK;

	logic [7:0] mem [DEPTH];

	logic          busy_q;
	chunk_hdr_t    hdr_q;
	logic          bank_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;

	logic          rd_s1;
	logic [CW-1:0] idx_s1;
	logic          last_s1;
	logic [7:0]    rdata_s1;

	logic          out_valid_q;
	chunk_hdr_t    out_hdr_q;
	logic [5:0]    out_idx_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;

	logic          out_fire;
	logic          issue;
	logic          is_last;
	logic [SW-1:0] slot;
	logic [AW-1:0] rd_addr;

	always_comb begin
		out_fire   = out_valid_q && chunk_out.ready;
		q_pop      = !busy_q && !q_stat.empty;
		// one read in flight, and only when the output register will have room for it
		issue      = busy_q && !rd_s1 && (!out_valid_q || out_fire);
		is_last    = (idx_q == cnt_q - 1'b1);
		slot       = {CHW'(hdr_q.channel), bank_q};
		rd_addr    = AW'(slot) * AW'(MAX_CHUNK) + AW'(idx_q);
		done_valid = issue && is_last;
		done_slot  = slot;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		if (issue)
			rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= issue;
			if (q_pop)
				busy_q <= 1'b1;
			else if (done_valid)
				busy_q <= 1'b0;
			if (rd_s1)
				out_valid_q <= 1'b1;
			else if (out_fire)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			hdr_q  <= q_hdr;
			bank_q <= q_bank;
			cnt_q  <= q_count;
			idx_q  <= '0;
		end else if (issue) begin
			idx_q <= idx_q + 1'b1;
		end
		if (issue) begin
			idx_s1  <= idx_q;
			last_s1 <= is_last;
		end
		if (rd_s1) begin
			out_hdr_q  <= hdr_q;
			out_idx_q  <= 6'(idx_s1);
			out_byte_q <= rdata_s1;
			out_last_q <= last_s1;
		end
	end

	assign chunk_out.valid         = out_valid_q;
	assign chunk_out.seq_no        = out_hdr_q.seq_no;
	assign chunk_out.chunk_channel = out_hdr_q.channel;
	assign chunk_out.open_ms       = out_hdr_q.open_ms;
	assign chunk_out.end_ms        = out_hdr_q.end_ms;
	assign chunk_out.byte_index    = out_idx_q;
	assign chunk_out.chunk_byte    = out_byte_q;
	assign chunk_out.last          = out_last_q;

	a_read_lands_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> !out_valid_q)
		else $error("read data arrived with the output register still full");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> busy_q && !rd_s1)
		else $error("chunk command taken while a chunk was in progress");

endmodule

// ===== tb/tb_idle_gap_byte_chunker_top.sv =====
// Self-checking testbench for the idle gap byte chunker: two-channel byte grouping, gap and limit closes.
module tb_idle_gap_byte_chunker_top;
	import igbc_pkg::*;

	localparam int MAX_CHUNK     = 48;
	localparam int LONG_HOLD     = 500;
	localparam int DRAIN_CYCLES  = 40;
	localparam int STUCK_LIMIT   = 6000;

	typedef struct packed {
		logic        func;
		logic        channel;
		logic [7:0]  rx_byte;
		logic [31:0] now_ms;
	} rx_item_t;

	typedef struct packed {
		logic [31:0] seq_no;
		logic        chunk_channel;
		logic [31:0] open_ms;
		logic [31:0] end_ms;
		logic [5:0]  byte_index;
		logic [7:0]  chunk_byte;
		logic        last;
	} chunk_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	rx_item_t              in_word = '0;
	logic                  out_ready = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_GAP_MS;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	igbc_in_if  item_in ();
	igbc_out_if chunk_out ();

	assign item_in.valid   = in_valid;
	assign item_in.func    = in_word.func;
	assign item_in.channel = in_word.channel;
	assign item_in.rx_byte = in_word.rx_byte;
	assign item_in.now_ms  = in_word.now_ms;
	assign chunk_out.ready = out_ready;

	idle_gap_byte_chunker_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_in),
		.chunk_out (chunk_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// chunk predictor state
	logic [7:0]  pend_data [2][MAX_CHUNK];
	int          pend_cnt [2] = '{0, 0};
	logic [31:0] first_ms [2];
	logic [31:0] latest_ms [2];
	logic [31:0] seq_ctr = '0;
	logic [15:0] gap_reg = GAP_MS_RESET;
	logic [5:0]  limit_reg = CHUNK_LIMIT_RESET;

	rx_item_t    item_q[$];
	chunk_word_t word_q[$];

	int items_queued = 0;
	int items_in = 0;
	int words_out = 0;
	int errors = 0;
	int hold_reqs = 0;
	int hold_done = 0;

	task automatic flush_chunk(input int ch);
		chunk_word_t w;
		if (pend_cnt[ch] == 0)
			return;
		seq_ctr = seq_ctr + 32'd1;
		for (int i = 0; i < pend_cnt[ch]; i++) begin
			w.seq_no        = seq_ctr;
			w.chunk_channel = ch[0];
			w.open_ms       = first_ms[ch];
			w.end_ms        = latest_ms[ch];
			w.byte_index    = i[5:0];
			w.chunk_byte    = pend_data[ch][i];
			w.last          = (i == pend_cnt[ch] - 1);
			word_q.push_back(w);
		end
		pend_cnt[ch] = 0;
	endtask

	task automatic absorb_item(input rx_item_t it);
		int          lim;
		int          ch;
		int          n;
		logic [31:0] since;
		ch  = int'(it.channel);
		lim = int'(limit_reg);
		if (lim == 0)
			lim = 1;
		if (lim > MAX_CHUNK)
			lim = MAX_CHUNK;
		since = it.now_ms - latest_ms[ch];
		if (pend_cnt[ch] != 0 && since >= {16'd0, gap_reg})
			flush_chunk(ch);
		if (it.func == FUNC_BYTE) begin
			n = pend_cnt[ch];
			if (n >= MAX_CHUNK) begin
				flush_chunk(ch);
				n = 0;
			end
			if (n == 0)
				first_ms[ch] = it.now_ms;
			latest_ms[ch] = it.now_ms;
			pend_data[ch][n] = it.rx_byte;
			pend_cnt[ch] = n + 1;
			if (n + 1 >= lim)
				flush_chunk(ch);
		end
	endtask

	// mostly short gaps, a few long ones, and now and then a run with none
	function automatic int next_gap(inout int free_run);
		if (free_run > 0) begin
			free_run--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			free_run = $urandom_range(20, 80);
			return 0;
		end
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(0, 2);
		return $urandom_range(4, 30);
	endfunction

	// sender
	int drv_wait = 0;
	int drv_free = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			// register writes must land only while idle, which the block does not enforce; mirror them here
			if (cfg_we) begin
				if (cfg_index == REG_GAP_MS)
					gap_reg = cfg_wdata[15:0];
				else
					limit_reg = cfg_wdata[5:0];
			end
			if (in_valid && item_in.ready) begin
				absorb_item(in_word);
				items_in++;
			end
			if (in_valid && !item_in.ready) begin
				// hold the word
			end else if (drv_wait > 0) begin
				drv_wait--;
				in_valid <= 1'b0;
			end else if (item_q.size() != 0) begin
				in_word  <= item_q.pop_front();
				in_valid <= 1'b1;
				drv_wait = next_gap(drv_free);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	int mon_wait = 0;
	int mon_free = 0;

	task automatic note_error(input string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic check_word();
		chunk_word_t want;
		if (word_q.size() == 0) begin
			note_error($sformatf("word with nothing pending: seq %0d ch %0d idx %0d",
				chunk_out.seq_no, chunk_out.chunk_channel, chunk_out.byte_index));
			return;
		end
		want = word_q.pop_front();
		words_out++;
		if (chunk_out.seq_no !== want.seq_no)
			note_error($sformatf("chunk %0d idx %0d: seq_no %0d, want %0d", want.seq_no,
				want.byte_index, chunk_out.seq_no, want.seq_no));
		if (chunk_out.chunk_channel !== want.chunk_channel)
			note_error($sformatf("chunk %0d idx %0d: channel %0d, want %0d", want.seq_no,
				want.byte_index, chunk_out.chunk_channel, want.chunk_channel));
		if (chunk_out.open_ms !== want.open_ms)
			note_error($sformatf("chunk %0d idx %0d: open_ms %h, want %h", want.seq_no,
				want.byte_index, chunk_out.open_ms, want.open_ms));
		if (chunk_out.end_ms !== want.end_ms)
			note_error($sformatf("chunk %0d idx %0d: end_ms %h, want %h", want.seq_no,
				want.byte_index, chunk_out.end_ms, want.end_ms));
		if (chunk_out.byte_index !== want.byte_index)
			note_error($sformatf("chunk %0d: byte_index %0d, want %0d", want.seq_no,
				chunk_out.byte_index, want.byte_index));
		if (chunk_out.chunk_byte !== want.chunk_byte)
			note_error($sformatf("chunk %0d idx %0d: byte %h, want %h", want.seq_no,
				want.byte_index, chunk_out.chunk_byte, want.chunk_byte));
		if (chunk_out.last !== want.last)
			note_error($sformatf("chunk %0d idx %0d: last %0d, want %0d", want.seq_no,
				want.byte_index, chunk_out.last, want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (chunk_out.valid && out_ready) begin
				check_word();
				mon_wait = next_gap(mon_free);
			end
			if (hold_done != hold_reqs) begin
				// long back-pressure so the block fills and stalls its input
				hold_done++;
				mon_wait = LONG_HOLD;
				out_ready <= 1'b0;
			end else if (mon_wait > 0) begin
				mon_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog: cycles with no word moving on either side
	int stuck_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && item_in.ready) || (chunk_out.valid && out_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles, %0d words outstanding",
				STUCK_LIMIT, word_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// stimulus
	logic [31:0] tgen [2] = '{32'd0, 32'd0};
	int          gap_set = int'(GAP_MS_RESET);

	task automatic add_item(input logic f, input logic ch, input logic [7:0] b,
		input logic [31:0] t);
		item_q.push_back({f, ch, b, t});
		items_queued++;
	endtask

	task automatic set_regs(input logic [15:0] g, input logic [5:0] l);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GAP_MS;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_index <= REG_CHUNK_LIMIT;
		cfg_wdata <= {{(CFG_DATA_W-6){1'b0}}, l};
		@(posedge clk);
		cfg_we <= 1'b0;
		gap_set = int'(g);
	endtask

	// wait until every item is in and every word is out, then let the pipe drain
	task automatic settle();
		while (items_in != items_queued || word_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int n, input int ch0_pct, input int byte_pct);
		logic        ch;
		logic [31:0] t;
		int          r;
		for (int k = 0; k < n; k++) begin
			ch = ($urandom_range(0, 99) >= ch0_pct);
			r  = $urandom_range(0, 99);
			if (r < 8)
				t = $urandom();
			else if (r < 28)
				t = tgen[ch] + gap_set + $urandom_range(0, 40);
			else if (gap_set == 0)
				t = tgen[ch] + $urandom_range(0, 3);
			else
				t = tgen[ch] + $urandom_range(0, gap_set - 1);
			tgen[ch] = t;
			add_item(($urandom_range(0, 99) < byte_pct) ? FUNC_BYTE : FUNC_TICK, ch,
				8'($urandom_range(0, 255)), t);
		end
	endtask

	int directed_items;
	int g_pick;
	int l_pick;

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: gap 20, limit 48
		add_item(FUNC_BYTE, 1'b0, 8'h00, 32'd0);
		add_item(FUNC_BYTE, 1'b0, 8'hFF, 32'd19);
		add_item(FUNC_TICK, 1'b0, 8'h00, 32'd38);
		add_item(FUNC_TICK, 1'b0, 8'h00, 32'd39);           // gap exactly reached
		add_item(FUNC_TICK, 1'b1, 8'h00, 32'd100);          // nothing pending
		add_item(FUNC_BYTE, 1'b1, 8'hA5, 32'hFFFF_FFF0);
		add_item(FUNC_BYTE, 1'b1, 8'h5A, 32'h0000_0004);    // gap across time wrap
		add_item(FUNC_BYTE, 1'b0, 8'h11, 32'd50);
		add_item(FUNC_BYTE, 1'b0, 8'h22, 32'd51);
		add_item(FUNC_BYTE, 1'b0, 8'h33, 32'd52);
		settle();

		// limit dropped under the pending count; gap at its top
		set_regs(16'hFFFF, 6'd2);
		add_item(FUNC_BYTE, 1'b0, 8'h44, 32'd53);
		add_item(FUNC_BYTE, 1'b1, 8'hC3, 32'h8000_0000);
		settle();

		// zero gap and zero limit: old chunk then a one-byte chunk in one step
		set_regs(16'd0, 6'd0);
		add_item(FUNC_BYTE, 1'b1, 8'h3C, 32'h8000_0000);
		add_item(FUNC_BYTE, 1'b0, 8'hFF, 32'hFFFF_FFFF);
		add_item(FUNC_TICK, 1'b0, 8'h00, 32'd0);
		settle();

		// limit above the chunk size is clamped
		set_regs(16'hFFFF, 6'd63);
		add_item(FUNC_BYTE, 1'b0, 8'h01, 32'd0);
		add_item(FUNC_BYTE, 1'b0, 8'h80, 32'd65534);
		add_item(FUNC_TICK, 1'b0, 8'h00, 32'd131068);
		add_item(FUNC_TICK, 1'b0, 8'h00, 32'd131069);
		settle();

		set_regs(16'd1, 6'd49);
		add_item(FUNC_BYTE, 1'b1, 8'h7E, 32'd7);
		add_item(FUNC_BYTE, 1'b1, 8'h81, 32'd7);
		add_item(FUNC_TICK, 1'b1, 8'h00, 32'd8);
		settle();
		directed_items = items_queued;

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin
					set_regs(16'hFFFF, 6'd4);
					hold_reqs <= hold_reqs + 1;
					run_random(60, 50, 95);
				end
				1: begin
					set_regs(16'hFFFF, 6'd48);
					run_random(60, 85, 95);
				end
				default: begin
					case ($urandom_range(0, 7))
						0: g_pick = 0;
						1: g_pick = 1;
						2: g_pick = 2;
						3: g_pick = 20;
						4: g_pick = 65535;
						5: g_pick = $urandom_range(3, 200);
						default: g_pick = $urandom_range(1, 65535);
					endcase
					case ($urandom_range(0, 6))
						0: l_pick = 0;
						1: l_pick = 1;
						2: l_pick = 48;
						3: l_pick = 63;
						4: l_pick = $urandom_range(49, 63);
						default: l_pick = $urandom_range(2, 12);
					endcase
					set_regs(g_pick[15:0], l_pick[5:0]);
					run_random(30, 50, 80);
				end
			endcase
			settle();
		end

		if (word_q.size() != 0)
			note_error($sformatf("%0d expected words never arrived", word_q.size()));
		$display("Run: %0d items (%0d directed), %0d chunk words in %0d chunks checked",
			items_in, directed_items, words_out, seq_ctr);
		$display("Gap 0..65535 and limit 0..63 incl. clamped values; one %0d-cycle output hold",
			LONG_HOLD);
		if (errors == 0 && word_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
